[design/ntbd_pkg.sv]
// package: shared types and constants for the nsec type bitmap decoder
`default_nettype none
package ntbd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int BIT_W  = 3;
    localparam int TYPE_W = 16;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [TYPE_W-1:0] t_type_code;

    typedef enum logic [2:0] {
        ST_TYPE     = 3'd0,
        ST_DONE     = 3'd1,
        ST_SHORT    = 3'd2,
        ST_OVERLONG = 3'd3,
        ST_PAST     = 3'd4
    } t_status;

endpackage
`default_nettype wire

[design/ntbd_in_if.sv]
// interface: input byte channel of the nsec type bitmap decoder
`default_nettype none
interface ntbd_in_if;
    logic               valid;
    logic               ready;
    ntbd_pkg::t_byte    data_byte;
    logic               end_of_blob;

    modport source (output valid, output data_byte, output end_of_blob, input ready);
    modport sink   (input valid, input data_byte, input end_of_blob, output ready);
endinterface
`default_nettype wire

[design/ntbd_out_if.sv]
// interface: result channel of the nsec type bitmap decoder
`default_nettype none
interface ntbd_out_if;
    logic                  valid;
    logic                  ready;
    ntbd_pkg::t_type_code  type_code;
    ntbd_pkg::t_status     status;
    logic                  last_of_run;

    modport source (output valid, output type_code, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input type_code, input status, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

[design/nsec_type_bitmap_decoder.sv]
// top level: dnssec type bitmap decoder, one blob byte per item, one result per cycle
// the result rate holds while o_out.ready is high; an accepted item is held in the
// pending results, then loaded result by result into the single result register;
// a data byte yields one type result per set bit, an end of blob byte a status result;
// a new item is taken while the last result of the previous one is being loaded out
// reset: synchronous active low, parser returns to window phase, result queue empties
`default_nettype none
module nsec_type_bitmap_decoder #(
    parameter int MAX_WINDOW_BYTES = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ntbd_in_if.sink      i_in,
    ntbd_out_if.source   o_out
);

    localparam int LW = $clog2(MAX_WINDOW_BYTES + 1);
    localparam ntbd_pkg::t_byte LEN_MAX = ntbd_pkg::BYTE_W'(MAX_WINDOW_BYTES);

    typedef enum logic [1:0] {
        PH_WINDOW = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    // parser state
    t_phase                    r_phase, n_phase;
    logic                      r_first, n_first;
    ntbd_pkg::t_byte           r_win, n_win;
    logic [LW-1:0]             r_left, n_left;
    logic [ntbd_pkg::POS_W-1:0] r_pos, n_pos;

    // pending results of one item
    logic                      r_busy;
    ntbd_pkg::t_byte           r_bmask;
    ntbd_pkg::t_byte           r_bwin;
    logic [ntbd_pkg::POS_W-1:0] r_bpos;
    logic                      r_bst_pend;
    ntbd_pkg::t_status         r_bst;

    // result register
    logic                      r_ovalid;
    ntbd_pkg::t_type_code      r_otype;
    ntbd_pkg::t_status         r_ost;
    logic                      r_olast;

    logic                      accept;
    logic                      last;
    ntbd_pkg::t_byte           b;
    ntbd_pkg::t_byte           d_mask;
    logic                      d_has_st;
    ntbd_pkg::t_status         d_st;
    logic [LW-1:0]             remaining;

    logic [ntbd_pkg::BIT_W-1:0] pick_idx;
    ntbd_pkg::t_byte           rest_mask;
    logic                      pick_is_type;
    logic                      pick_last;
    ntbd_pkg::t_type_code      pick_type;
    ntbd_pkg::t_status         pick_st;
    logic                      out_load;
    logic                      buf_free;

    assign b      = i_in.data_byte;
    assign last   = i_in.end_of_blob;
    assign accept = i_in.valid && i_in.ready;

    // parse one byte
    always_comb begin
        n_phase   = r_phase;
        n_first   = 1'b0;
        n_win     = r_win;
        n_left    = r_left;
        n_pos     = r_pos;
        d_mask    = '0;
        d_has_st  = 1'b0;
        d_st      = ntbd_pkg::ST_DONE;
        remaining = (r_left != '0) ? (r_left - LW'(1)) : '0;
        case (r_phase)
            PH_WINDOW: begin
                if (last) begin
                    d_has_st = 1'b1;
                    d_st     = r_first ? ntbd_pkg::ST_SHORT : ntbd_pkg::ST_DONE;
                end else begin
                    n_win   = b;
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (r_win == '0 && b == '0) begin
                    if (last) begin
                        d_has_st = 1'b1;
                        d_st     = ntbd_pkg::ST_DONE;
                    end else begin
                        n_win   = ntbd_pkg::BYTE_W'(ntbd_pkg::ST_DONE);
                        n_phase = PH_SKIP;
                    end
                end else if (b > LEN_MAX) begin
                    if (last) begin
                        d_has_st = 1'b1;
                        d_st     = ntbd_pkg::ST_OVERLONG;
                    end else begin
                        n_win   = ntbd_pkg::BYTE_W'(ntbd_pkg::ST_OVERLONG);
                        n_phase = PH_SKIP;
                    end
                end else if (b == '0) begin
                    if (last) begin
                        d_has_st = 1'b1;
                        d_st     = ntbd_pkg::ST_DONE;
                    end else begin
                        n_phase = PH_WINDOW;
                    end
                end else begin
                    if (last) begin
                        d_has_st = 1'b1;
                        d_st     = ntbd_pkg::ST_PAST;
                    end else begin
                        n_left  = b[LW-1:0];
                        n_pos   = '0;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (last && remaining != '0) begin
                    d_has_st = 1'b1;
                    d_st     = ntbd_pkg::ST_PAST;
                end else begin
                    d_mask = b;
                    n_left = remaining;
                    n_pos  = r_pos + ntbd_pkg::POS_W'(1);
                    if (last) begin
                        d_has_st = 1'b1;
                        d_st     = ntbd_pkg::ST_DONE;
                    end else if (remaining == '0) begin
                        n_phase = PH_WINDOW;
                    end
                end
            end
            PH_SKIP: begin
                if (last) begin
                    d_has_st = 1'b1;
                    d_st     = ntbd_pkg::t_status'(r_win[2:0]);
                end
            end
            default: begin
                n_phase = PH_WINDOW;
            end
        endcase
        // end of blob returns everything to reset values
        if (last) begin
            n_phase = PH_WINDOW;
            n_first = 1'b1;
            n_win   = '0;
            n_left  = '0;
            n_pos   = '0;
        end
    end

    // pick the next result, most significant bit first
    always_comb begin
        pick_idx = '0;
        for (int k = 0; k < ntbd_pkg::BYTE_W; k++) begin
            if (r_bmask[k]) begin
                pick_idx = ntbd_pkg::BIT_W'(ntbd_pkg::BYTE_W - 1 - k);
            end
        end
        pick_is_type = (r_bmask != '0);
        rest_mask    = r_bmask & ~(ntbd_pkg::t_byte'(8'h80) >> pick_idx);
        if (pick_is_type) begin
            pick_type = {r_bwin, r_bpos, pick_idx};
            pick_st   = ntbd_pkg::ST_TYPE;
            pick_last = (rest_mask == '0) && !r_bst_pend;
        end else begin
            pick_type = '0;
            pick_st   = r_bst;
            pick_last = 1'b1;
        end
    end

    assign out_load   = r_busy && (!r_ovalid || o_out.ready);
    assign buf_free   = !r_busy || (out_load && pick_last);
    assign i_in.ready = buf_free;

    assign o_out.valid       = r_ovalid;
    assign o_out.type_code   = r_otype;
    assign o_out.status      = r_ost;
    assign o_out.last_of_run = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WINDOW;
            r_first    <= 1'b1;
            r_win      <= '0;
            r_left     <= '0;
            r_pos      <= '0;
            r_busy     <= 1'b0;
            r_bst_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_first <= n_first;
                r_win   <= n_win;
                r_left  <= n_left;
                r_pos   <= n_pos;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (accept && (d_mask != '0 || d_has_st)) begin
                r_busy     <= 1'b1;
                r_bmask    <= d_mask;
                r_bwin     <= r_win;
                r_bpos     <= r_pos;
                r_bst_pend <= d_has_st;
                r_bst      <= d_st;
            end else if (out_load) begin
                r_bmask <= rest_mask;
                if (!pick_is_type) begin
                    r_bst_pend <= 1'b0;
                end
                if (pick_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (out_load) begin
            r_otype <= pick_type;
            r_ost   <= pick_st;
            r_olast <= pick_last;
        end
    end

    // a status result always closes the run of its item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ntbd_pkg::ST_TYPE) |-> o_out.last_of_run)
        else $error("status result without last_of_run");

    // status results carry a zero type code
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ntbd_pkg::ST_TYPE) |-> (o_out.type_code == '0))
        else $error("nonzero type code on status result");

    // end of blob restores the parser
    a_blob_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_first && r_phase == PH_WINDOW && r_left == '0))
        else $error("parser not reset after end of blob");

    // the queue is only refilled as its last pending result is loaded out
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_load) |-> !i_in.ready)
        else $error("item accepted while results pending");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench: directed and random type bitmap blobs checked against a behavioral decoder
module testbench;

    localparam int MAX_WIN_BYTES = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 200;

    typedef enum logic [1:0] {
        PH_WINDOW,
        PH_LENGTH,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        ntbd_pkg::t_type_code type_code;
        ntbd_pkg::t_status    status;
        logic                 last_of_run;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    ntbd_in_if  in_ch ();
    ntbd_out_if out_ch ();

    nsec_type_bitmap_decoder #(
        .MAX_WINDOW_BYTES(MAX_WIN_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_phase            dec_phase;
    logic              dec_first;
    ntbd_pkg::t_byte   dec_window;
    logic [5:0]        dec_left;
    logic [4:0]        dec_pos;
    ntbd_pkg::t_status dec_skip_status;

    t_result           expected_results[$];
    ntbd_pkg::t_byte   blob_buf[$];
    int                mismatch_count;
    int                cycle_count;
    int                bytes_sent;
    int                hold_off_len;
    bit                src_idle_en;
    bit                snk_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result mk_result(ntbd_pkg::t_type_code code, ntbd_pkg::t_status st);
        t_result r;
        r.type_code   = code;
        r.status      = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic void reset_decoder();
        dec_phase       = PH_WINDOW;
        dec_first       = 1'b1;
        dec_window      = '0;
        dec_left        = '0;
        dec_pos         = '0;
        dec_skip_status = ntbd_pkg::ST_DONE;
    endfunction

    // expected results of one accepted blob byte
    function automatic void decode_byte(ntbd_pkg::t_byte b, logic eob);
        t_result    run[$];
        logic       was_first;
        logic [5:0] remaining;
        was_first = dec_first;
        dec_first = 1'b0;
        case (dec_phase)
            PH_WINDOW: begin
                if (eob) begin
                    run.push_back(mk_result('0, was_first ? ntbd_pkg::ST_SHORT
                                                          : ntbd_pkg::ST_DONE));
                end else begin
                    dec_window = b;
                    dec_phase  = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (dec_window == 8'h00 && b == 8'h00) begin
                    if (eob) begin
                        run.push_back(mk_result('0, ntbd_pkg::ST_DONE));
                    end else begin
                        dec_skip_status = ntbd_pkg::ST_DONE;
                        dec_phase       = PH_SKIP;
                    end
                end else if (b > MAX_WIN_BYTES) begin
                    if (eob) begin
                        run.push_back(mk_result('0, ntbd_pkg::ST_OVERLONG));
                    end else begin
                        dec_skip_status = ntbd_pkg::ST_OVERLONG;
                        dec_phase       = PH_SKIP;
                    end
                end else if (b == 8'h00) begin
                    if (eob) begin
                        run.push_back(mk_result('0, ntbd_pkg::ST_DONE));
                    end else begin
                        dec_phase = PH_WINDOW;
                    end
                end else begin
                    if (eob) begin
                        run.push_back(mk_result('0, ntbd_pkg::ST_PAST));
                    end else begin
                        dec_left  = b[5:0];
                        dec_pos   = '0;
                        dec_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                remaining = (dec_left != 6'd0) ? dec_left - 6'd1 : 6'd0;
                if (eob && remaining != 6'd0) begin
                    run.push_back(mk_result('0, ntbd_pkg::ST_PAST));
                end else begin
                    // msb first
                    for (int i = 0; i < 8; i++) begin
                        if (b[7-i]) begin
                            run.push_back(mk_result({dec_window, dec_pos, 3'(i)},
                                                    ntbd_pkg::ST_TYPE));
                        end
                    end
                    dec_left = remaining;
                    dec_pos  = dec_pos + 5'd1;
                    if (eob) begin
                        run.push_back(mk_result('0, ntbd_pkg::ST_DONE));
                    end else if (remaining == 6'd0) begin
                        dec_phase = PH_WINDOW;
                    end
                end
            end
            default: begin
                if (eob) begin
                    run.push_back(mk_result('0, dec_skip_status));
                end
            end
        endcase
        if (eob) begin
            reset_decoder();
        end
        if (run.size() > 0) begin
            run[run.size()-1].last_of_run = 1'b1;
        end
        foreach (run[k]) begin
            expected_results.push_back(run[k]);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_byte(ntbd_pkg::t_byte b, logic eob);
        bit taken;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_blob <= eob;
        taken = 1'b0;
        // ready is stable between edges, so look at it mid cycle
        while (!taken) begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end
        decode_byte(b, eob);
        bytes_sent++;
    endtask

    task automatic send_blob();
        foreach (blob_buf[k]) begin
            send_byte(blob_buf[k], k == blob_buf.size() - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well formed windows, the rest broken or noise
    task automatic make_random_blob();
        int              kind;
        int              n_win;
        int              len;
        int              cut;
        ntbd_pkg::t_byte win;
        ntbd_pkg::t_byte data;
        kind  = $urandom_range(0, 99);
        n_win = $urandom_range(1, 3);
        blob_buf.delete();
        repeat (n_win) begin
            case ($urandom_range(0, 5))
                0:       win = 8'h00;
                1:       win = 8'hff;
                default: win = ntbd_pkg::t_byte'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = $urandom_range(17, MAX_WIN_BYTES);
                default: len = $urandom_range(1, 4);
            endcase
            blob_buf.push_back(win);
            blob_buf.push_back(ntbd_pkg::t_byte'(len));
            repeat (len) begin
                case ($urandom_range(0, 7))
                    0:       data = 8'h00;
                    1:       data = 8'hff;
                    default: data = ntbd_pkg::t_byte'($urandom_range(0, 255));
                endcase
                blob_buf.push_back(data);
            end
        end
        if (kind >= 92) begin
            blob_buf.delete();
            repeat ($urandom_range(1, 6)) begin
                blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(0, 255)));
            end
        end else if (kind >= 86) begin
            blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(0, 255)));
            blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(MAX_WIN_BYTES + 1, 255)));
            repeat ($urandom_range(0, 3)) begin
                blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(0, 255)));
            end
        end else if (kind >= 78) begin
            cut      = $urandom_range(1, blob_buf.size() - 1);
            blob_buf = blob_buf[0:cut-1];
        end else if (kind >= 72) begin
            blob_buf.push_back(8'h00);
            blob_buf.push_back(8'h00);
            repeat ($urandom_range(0, 3)) begin
                blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(0, 255)));
            end
        end else if (kind >= 66) begin
            // lone trailing byte
            blob_buf.push_back(ntbd_pkg::t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        blob_buf = '{8'h00};
        send_blob();
        blob_buf = '{8'h00, 8'h00, 8'hab, 8'hcd};
        send_blob();
        blob_buf = '{8'h05, 8'h00, 8'h06, 8'h01, 8'h80, 8'h07};
        send_blob();
        blob_buf = '{8'h01, 8'd33, 8'hff};
        send_blob();
        blob_buf = '{8'h02, 8'hff};
        send_blob();
        blob_buf = '{8'hff, 8'h02, 8'hff};
        send_blob();
        blob_buf = '{8'h03, 8'h04};
        send_blob();
        blob_buf = '{8'hff, 8'h01, 8'hff};
        send_blob();
        wait_drained();
    endtask

    task automatic test_pressure();
        src_idle_en  = 1'b0;
        snk_idle_en  = 1'b0;
        hold_off_len = HOLD_CYCLES;
        blob_buf = '{8'h10, 8'h08};
        repeat (8) blob_buf.push_back(8'hff);
        send_blob();
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_bytes, bit with_idle);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            src_idle_en = with_idle && ($urandom_range(0, 3) != 0);
            snk_idle_en = with_idle && ($urandom_range(0, 3) != 0);
            make_random_blob();
            send_blob();
        end
        wait_drained();
    endtask

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
                out_ch.ready <= 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // handshake signals settle between edges, so the result taken at the
    // next rising edge is checked mid cycle
    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result type_code %0d status %0d",
                                          out_ch.type_code, out_ch.status));
            end else begin
                t_result want;
                want = expected_results.pop_front();
                if (out_ch.type_code !== want.type_code) begin
                    report_mismatch($sformatf("type_code got %0d want %0d",
                                              out_ch.type_code, want.type_code));
                end
                if (out_ch.status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_ch.status, want.status));
                end
                if (out_ch.last_of_run !== want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run got %0b want %0b",
                                              out_ch.last_of_run, want.last_of_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nsec_type_bitmap_decoder test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.end_of_blob = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        bytes_sent        = 0;
        hold_off_len      = 0;
        src_idle_en       = 1'b0;
        snk_idle_en       = 1'b0;
        reset_decoder();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_pressure();
        test_random_traffic(320, 1'b1);
        test_random_traffic(80, 1'b0);
        if (mismatch_count == 0) begin
            $display("nsec_type_bitmap_decoder test passed");
        end else begin
            $display("nsec_type_bitmap_decoder test failed");
        end
        $finish;
    end

endmodule

[nsec_type_bitmap_decoder.f]
design/ntbd_pkg.sv
design/ntbd_in_if.sv
design/ntbd_out_if.sv
design/nsec_type_bitmap_decoder.sv
verif/testbench.sv
